// File: rtl/popularity_driven_replica_placer_macros.svh
// assertion helpers for the replica placer
`ifndef POPULARITY_DRIVEN_REPLICA_PLACER_MACROS_SVH
`define POPULARITY_DRIVEN_REPLICA_PLACER_MACROS_SVH

// check that holds outside reset
`define PDRP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// check that also covers the reset cycles
`define PDRP_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// File: rtl/pdrp_pkg.sv
// ---------------------------------------------------------------------------
// pdrp_pkg
// shared types and constants of the popularity driven replica placer
// ---------------------------------------------------------------------------
`default_nettype none

package pdrp_pkg;

   localparam int REPLICA_ENTRIES_DEF    = 256;
   localparam int POPULARITY_ENTRIES_DEF = 64;
   localparam int MAX_REPLICAS_DEF       = 16;
   localparam int RESULT_LIMIT           = 16;
   localparam int QUEUE_DEPTH            = 4;

   localparam logic [10:0] NODE_COUNT_RST       = 11'd8;
   localparam logic [4:0]  DEFAULT_REPLICAS_RST = 5'd3;
   localparam logic [7:0]  BOOST_PERIOD_RST     = 8'd10;
   localparam logic [3:0]  BOOST_COUNT_RST      = 4'd2;
   localparam logic [10:0] MAX_NODES            = 11'd1024;

   localparam logic OP_PLACE  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT,
      CSR_DEFAULT_REPLICAS,
      CSR_BOOST_PERIOD,
      CSR_BOOST_COUNT
   } csr_index_type;

   typedef struct packed {
      logic        op;
      logic [15:0] data_id;
      logic [15:0] popularity_count;
      logic        entry_valid;
      logic        end_of_report;
   } req_word_type;

   typedef struct packed {
      logic [9:0] node;
      logic [4:0] replica_count;
      logic       last;
      logic       round_cleared;
      logic       table_full;
   } rsp_word_type;

   // classified item between front and back
   typedef struct packed {
      logic        is_report;
      logic        has_entry;
      logic        eor;
      logic [15:0] data_id;
      logic [15:0] add;
   } work_type;

   typedef struct packed {
      logic [10:0] modulus;
      logic [4:0]  default_replicas;
      logic [7:0]  period;
      logic [3:0]  boosts;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSCAN,
      ST_DIV,
      ST_EMIT,
      ST_PSCAN,
      ST_EOR,
      ST_BNEXT,
      ST_BMAX,
      ST_BFIND,
      ST_ACK
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/pdrp_ram.sv
// ---------------------------------------------------------------------------
// pdrp_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module pdrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/pdrp_front.sv
// ---------------------------------------------------------------------------
// pdrp_front
// takes request words, classifies them and queues them for the back end
// ---------------------------------------------------------------------------
`default_nettype none

module pdrp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire pdrp_pkg::req_word_type req_word,
   output logic                       q_valid,
   output pdrp_pkg::work_type         q_item,
   input  wire logic                  q_pop
);

   localparam int QD  = pdrp_pkg::QUEUE_DEPTH;
   localparam int QAW = $clog2(QD);

   pdrp_pkg::work_type q_ff [QD];
   logic [QAW-1:0] wptr_ff, wptr_in;
   logic [QAW-1:0] rptr_ff, rptr_in;
   logic [QAW:0]   qcnt_ff, qcnt_in;
   logic           do_push, do_pop;
   pdrp_pkg::work_type cls;

   always_comb begin
      cls.is_report = (req_word.op == pdrp_pkg::OP_REPORT);
      cls.has_entry = cls.is_report && req_word.entry_valid;
      cls.eor       = cls.is_report && req_word.end_of_report;
      cls.data_id   = req_word.data_id;
      cls.add       = req_word.popularity_count;
   end

   assign req_full = (qcnt_ff == (QAW+1)'(QD));
   assign q_valid  = (qcnt_ff != '0);
   assign q_item   = q_ff[rptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      qcnt_in = qcnt_ff;
      if (do_push && !do_pop) begin
         qcnt_in = qcnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         qcnt_in = qcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pdrp_back.sv
// ---------------------------------------------------------------------------
// pdrp_back
// sequencer over the replica and popularity tables, result register
// ---------------------------------------------------------------------------
`default_nettype none

module pdrp_back #(
   parameter int REPLICA_ENTRIES    = pdrp_pkg::REPLICA_ENTRIES_DEF,
   parameter int POPULARITY_ENTRIES = pdrp_pkg::POPULARITY_ENTRIES_DEF,
   parameter int MAX_REPLICAS       = pdrp_pkg::MAX_REPLICAS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pdrp_pkg::cfg_type      cfg,
   input  wire logic                   q_valid,
   input  wire pdrp_pkg::work_type     q_item,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output pdrp_pkg::rsp_word_type      rsp_word
);

   localparam int RAW = $clog2(REPLICA_ENTRIES);
   localparam int PAW = $clog2(POPULARITY_ENTRIES);
   localparam int RFW = $clog2(REPLICA_ENTRIES + 1);
   localparam int PFW = $clog2(POPULARITY_ENTRIES + 1);
   localparam int CW  = $clog2(MAX_REPLICAS + 1);
   localparam int SIW = (RFW > PFW) ? RFW : PFW;
   localparam int RWW = 16 + CW;
   localparam int PWW = 48;

   pdrp_pkg::back_state_type state_ff, state_in;
   pdrp_pkg::work_type       work_ff, work_in;
   pdrp_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           full_ff, full_in;
   logic [RFW-1:0] rfill_ff, rfill_in;
   logic [PFW-1:0] pfill_ff, pfill_in;
   logic [7:0]     counter_ff, counter_in;
   logic [SIW-1:0] sidx_ff, sidx_in;
   logic           chk_ff, chk_in;
   logic [SIW-1:0] chk_idx_ff, chk_idx_in;
   logic [PAW-1:0] best_idx_ff, best_idx_in;
   logic [31:0]    best_cnt_ff, best_cnt_in;
   logic [15:0]    best_id_ff, best_id_in;
   logic [3:0]     k_ff, k_in;
   logic [9:0]     rem_ff, rem_in;
   logic [15:0]    dsh_ff, dsh_in;
   logic [3:0]     dcnt_ff, dcnt_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [4:0]     left_ff, left_in;
   logic [9:0]     node_ff, node_in;

   logic           r_we, p_we;
   logic [RAW-1:0] r_waddr;
   logic [PAW-1:0] p_waddr;
   logic [RWW-1:0] r_wdata, r_rdata;
   logic [PWW-1:0] p_wdata, p_rdata;
   logic [15:0]    r_id, p_id, key;
   logic [CW-1:0]  r_cnt, dflt;
   logic [31:0]    p_cnt, sat;
   logic [32:0]    psum;
   logic [SIW-1:0] scan_fill;
   logic           scanning, issue, scan_end, r_hit, p_hit, out_free;
   logic [10:0]    div_t, node_inc;
   logic [9:0]     div_rem;
   logic [7:0]     cnt_new;

   pdrp_ram #(.WIDTH(RWW), .DEPTH(REPLICA_ENTRIES)) u_replica_ram (
      .clock     (clock),
      .wr_en     (r_we),
      .wr_addr   (r_waddr),
      .wr_data   (r_wdata),
      .rd_addr   (sidx_ff[RAW-1:0]),
      .rd_data_ff(r_rdata)
   );

   pdrp_ram #(.WIDTH(PWW), .DEPTH(POPULARITY_ENTRIES)) u_pop_ram (
      .clock     (clock),
      .wr_en     (p_we),
      .wr_addr   (p_waddr),
      .wr_data   (p_wdata),
      .rd_addr   (sidx_ff[PAW-1:0]),
      .rd_data_ff(p_rdata)
   );

   assign r_id  = r_rdata[RWW-1:CW];
   assign r_cnt = r_rdata[CW-1:0];
   assign p_id  = p_rdata[47:32];
   assign p_cnt = p_rdata[31:0];

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      if (cfg.default_replicas == '0) begin
         dflt = CW'(1);
      end else if (int'(cfg.default_replicas) > MAX_REPLICAS) begin
         dflt = CW'(MAX_REPLICAS);
      end else begin
         dflt = CW'(cfg.default_replicas);
      end
   end

   assign psum     = {1'b0, p_cnt} + 33'(work_ff.add);
   assign sat      = psum[32] ? '1 : psum[31:0];
   assign div_t    = {rem_ff, dsh_ff[15]};
   assign div_rem  = (div_t >= cfg.modulus) ? 10'(div_t - cfg.modulus) : div_t[9:0];
   assign node_inc = 11'(node_ff) + 11'd1;
   assign cnt_new  = counter_ff + 8'd1;
   assign out_free = !rsp_valid_ff || rsp_pop;

   always_comb begin
      case (state_ff)
         pdrp_pkg::ST_RSCAN, pdrp_pkg::ST_BFIND: begin
            scanning  = 1'b1;
            scan_fill = SIW'(rfill_ff);
         end
         pdrp_pkg::ST_PSCAN, pdrp_pkg::ST_BMAX: begin
            scanning  = 1'b1;
            scan_fill = SIW'(pfill_ff);
         end
         default: begin
            scanning  = 1'b0;
            scan_fill = '0;
         end
      endcase
   end

   assign key      = (state_ff == pdrp_pkg::ST_BFIND) ? best_id_ff : work_ff.data_id;
   assign issue    = (sidx_ff < scan_fill);
   assign scan_end = !chk_ff && !issue;
   assign r_hit    = chk_ff && (r_id == key);
   assign p_hit    = chk_ff && (p_id == key);

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      full_in      = full_ff;
      rfill_in     = rfill_ff;
      pfill_in     = pfill_ff;
      counter_in   = counter_ff;
      sidx_in      = sidx_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      best_idx_in  = best_idx_ff;
      best_cnt_in  = best_cnt_ff;
      best_id_in   = best_id_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      dcnt_in      = dcnt_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      node_in      = node_ff;
      q_pop        = 1'b0;
      r_we         = 1'b0;
      r_waddr      = '0;
      r_wdata      = '0;
      p_we         = 1'b0;
      p_waddr      = '0;
      p_wdata      = '0;

      // one table entry read per cycle, compared in the next cycle
      if (scanning) begin
         chk_in     = issue;
         chk_idx_in = sidx_ff;
         if (issue) begin
            sidx_in = sidx_ff + 1'b1;
         end
      end

      case (state_ff)
         pdrp_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               work_in = q_item;
               full_in = 1'b0;
               sidx_in = '0;
               chk_in  = 1'b0;
               if (!q_item.is_report) begin
                  state_in = pdrp_pkg::ST_RSCAN;
               end else if (q_item.has_entry) begin
                  state_in = pdrp_pkg::ST_PSCAN;
               end else begin
                  state_in = pdrp_pkg::ST_EOR;
               end
            end
         end
         pdrp_pkg::ST_RSCAN: begin
            if (r_hit) begin
               chk_in   = 1'b0;
               cnt_in   = r_cnt;
               rem_in   = '0;
               dsh_in   = work_ff.data_id;
               dcnt_in  = '0;
               state_in = pdrp_pkg::ST_DIV;
            end else if (scan_end) begin
               if (rfill_ff == RFW'(REPLICA_ENTRIES)) begin
                  full_in  = 1'b1;
                  state_in = pdrp_pkg::ST_ACK;
               end else begin
                  r_we     = 1'b1;
                  r_waddr  = rfill_ff[RAW-1:0];
                  r_wdata  = {work_ff.data_id, dflt};
                  rfill_in = rfill_ff + 1'b1;
                  cnt_in   = dflt;
                  rem_in   = '0;
                  dsh_in   = work_ff.data_id;
                  dcnt_in  = '0;
                  state_in = pdrp_pkg::ST_DIV;
               end
            end
         end
         pdrp_pkg::ST_DIV: begin
            // restoring division, one id bit a cycle
            rem_in  = div_rem;
            dsh_in  = {dsh_ff[14:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 4'd15) begin
               node_in  = div_rem;
               left_in  = (int'(cnt_ff) > pdrp_pkg::RESULT_LIMIT) ?
                          5'(pdrp_pkg::RESULT_LIMIT) : 5'(cnt_ff);
               state_in = pdrp_pkg::ST_EMIT;
            end
         end
         pdrp_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.node            = node_ff;
               rsp_word_in.replica_count   = 5'(cnt_ff);
               rsp_word_in.last            = (left_ff == 5'd1);
               rsp_word_in.round_cleared   = (counter_ff == '0);
               rsp_word_in.table_full      = 1'b0;
               left_in = left_ff - 1'b1;
               node_in = (node_inc == cfg.modulus) ? '0 : node_inc[9:0];
               if (left_ff == 5'd1) begin
                  state_in = pdrp_pkg::ST_IDLE;
               end
            end
         end
         pdrp_pkg::ST_PSCAN: begin
            if (p_hit) begin
               chk_in   = 1'b0;
               p_we     = 1'b1;
               p_waddr  = chk_idx_ff[PAW-1:0];
               p_wdata  = {work_ff.data_id, sat};
               state_in = pdrp_pkg::ST_EOR;
            end else if (scan_end) begin
               if (pfill_ff == PFW'(POPULARITY_ENTRIES)) begin
                  full_in = 1'b1;
               end else begin
                  p_we     = 1'b1;
                  p_waddr  = pfill_ff[PAW-1:0];
                  p_wdata  = {work_ff.data_id, 16'd0, work_ff.add};
                  pfill_in = pfill_ff + 1'b1;
               end
               state_in = pdrp_pkg::ST_EOR;
            end
         end
         pdrp_pkg::ST_EOR: begin
            state_in = pdrp_pkg::ST_ACK;
            if (work_ff.eor) begin
               counter_in = cnt_new;
               if (cnt_new >= cfg.period) begin
                  k_in     = '0;
                  state_in = pdrp_pkg::ST_BNEXT;
               end
            end
         end
         pdrp_pkg::ST_BNEXT: begin
            if (k_ff == cfg.boosts || pfill_ff == '0) begin
               pfill_in   = '0;
               counter_in = '0;
               state_in   = pdrp_pkg::ST_ACK;
            end else begin
               sidx_in  = '0;
               chk_in   = 1'b0;
               state_in = pdrp_pkg::ST_BMAX;
            end
         end
         pdrp_pkg::ST_BMAX: begin
            // strict compare keeps the first entry on ties
            if (chk_ff && (chk_idx_ff == '0 || best_cnt_ff < p_cnt)) begin
               best_idx_in = chk_idx_ff[PAW-1:0];
               best_cnt_in = p_cnt;
               best_id_in  = p_id;
            end
            if (scan_end) begin
               sidx_in  = '0;
               chk_in   = 1'b0;
               state_in = pdrp_pkg::ST_BFIND;
            end
         end
         pdrp_pkg::ST_BFIND: begin
            if (r_hit || scan_end) begin
               if (r_hit && r_cnt < CW'(MAX_REPLICAS)) begin
                  r_we    = 1'b1;
                  r_waddr = chk_idx_ff[RAW-1:0];
                  r_wdata = {r_id, CW'(r_cnt + 1'b1)};
               end
               p_we     = 1'b1;
               p_waddr  = best_idx_ff;
               p_wdata  = {best_id_ff, 32'd0};
               chk_in   = 1'b0;
               k_in     = k_ff + 1'b1;
               state_in = pdrp_pkg::ST_BNEXT;
            end
         end
         pdrp_pkg::ST_ACK: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.node          = '0;
               rsp_word_in.replica_count = '0;
               rsp_word_in.last          = 1'b1;
               rsp_word_in.round_cleared = (counter_ff == '0);
               rsp_word_in.table_full    = full_ff;
               state_in                  = pdrp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdrp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdrp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rfill_ff     <= '0;
         pfill_ff     <= '0;
         counter_ff   <= '0;
         chk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rfill_ff     <= rfill_in;
         pfill_ff     <= pfill_in;
         counter_ff   <= counter_in;
         chk_ff       <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_word_ff <= rsp_word_in;
      full_ff     <= full_in;
      sidx_ff     <= sidx_in;
      chk_idx_ff  <= chk_idx_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
      best_id_ff  <= best_id_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      dcnt_ff     <= dcnt_in;
      cnt_ff      <= cnt_in;
      left_ff     <= left_in;
      node_ff     <= node_in;
   end

endmodule

`default_nettype wire

// File: rtl/popularity_driven_replica_placer.sv
// ---------------------------------------------------------------------------
// popularity_driven_replica_placer
// replica placement with popularity driven replica boosting
// ---------------------------------------------------------------------------
// Words are queued by the front end (four deep) and handled one at a time by
// the back end, which scans its tables one entry per cycle through a ram
// read port. A placement runs the id lookup, the id mod node_count division
// and then emits its result words. A report word with an entry scans the
// popularity table. A report that completes a round adds, per pick, a scan of
// the popularity table for the maximum and a scan of the replica table.
// Results sit in an output register, so the next word is taken while one
// waits. No clearing pass follows reset: fill counts guard the tables.
`default_nettype none

`include "popularity_driven_replica_placer_macros.svh"

module popularity_driven_replica_placer #(
   parameter int REPLICA_ENTRIES    = pdrp_pkg::REPLICA_ENTRIES_DEF,
   parameter int POPULARITY_ENTRIES = pdrp_pkg::POPULARITY_ENTRIES_DEF,
   parameter int MAX_REPLICAS       = pdrp_pkg::MAX_REPLICAS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire pdrp_pkg::req_word_type req_word,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output pdrp_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [10:0]            csr_wdata
);

   logic [10:0] node_count_ff, node_count_in;
   logic [4:0]  default_replicas_ff, default_replicas_in;
   logic [7:0]  boost_period_ff, boost_period_in;
   logic [3:0]  boost_count_ff, boost_count_in;
   pdrp_pkg::cfg_type  cfg;
   pdrp_pkg::work_type q_item;
   logic q_valid, q_pop;

   always_comb begin
      node_count_in       = node_count_ff;
      default_replicas_in = default_replicas_ff;
      boost_period_in     = boost_period_ff;
      boost_count_in      = boost_count_ff;
      if (csr_we) begin
         case (pdrp_pkg::csr_index_type'(csr_index))
            pdrp_pkg::CSR_NODE_COUNT:       node_count_in       = csr_wdata;
            pdrp_pkg::CSR_DEFAULT_REPLICAS: default_replicas_in = csr_wdata[4:0];
            pdrp_pkg::CSR_BOOST_PERIOD:     boost_period_in     = csr_wdata[7:0];
            pdrp_pkg::CSR_BOOST_COUNT:      boost_count_in      = csr_wdata[3:0];
            default: begin
               node_count_in = node_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff       <= pdrp_pkg::NODE_COUNT_RST;
         default_replicas_ff <= pdrp_pkg::DEFAULT_REPLICAS_RST;
         boost_period_ff     <= pdrp_pkg::BOOST_PERIOD_RST;
         boost_count_ff      <= pdrp_pkg::BOOST_COUNT_RST;
      end else begin
         node_count_ff       <= node_count_in;
         default_replicas_ff <= default_replicas_in;
         boost_period_ff     <= boost_period_in;
         boost_count_ff      <= boost_count_in;
      end
   end

   // modulus kept within 1..1024, zero period acts as one
   always_comb begin
      if (node_count_ff == '0) begin
         cfg.modulus = 11'd1;
      end else if (node_count_ff > pdrp_pkg::MAX_NODES) begin
         cfg.modulus = pdrp_pkg::MAX_NODES;
      end else begin
         cfg.modulus = node_count_ff;
      end
      cfg.default_replicas = default_replicas_ff;
      cfg.period           = (boost_period_ff == '0) ? 8'd1 : boost_period_ff;
      cfg.boosts           = boost_count_ff;
   end

   pdrp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_word(req_word),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   pdrp_back #(
      .REPLICA_ENTRIES   (REPLICA_ENTRIES),
      .POPULARITY_ENTRIES(POPULARITY_ENTRIES),
      .MAX_REPLICAS      (MAX_REPLICAS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_word (rsp_word)
   );

   `PDRP_ASSERT(a_node_in_range, !rsp_empty |-> (11'(rsp_word.node) < cfg.modulus))
   `PDRP_ASSERT(a_full_is_last, (!rsp_empty && rsp_word.table_full) |-> rsp_word.last)
   `PDRP_ASSERT(a_full_zero, (!rsp_empty && rsp_word.table_full) |-> (rsp_word.node == '0 && rsp_word.replica_count == '0))
   `PDRP_ASSERT_RST(a_reset_empty, reset |=> rsp_empty)

endmodule

`default_nettype wire

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// checks the replica placer against a cycle-free predictor
// ---------------------------------------------------------------------------
// A backlog of request words feeds a driver that idles in random bursts. Each
// word taken by the block runs through the predictor, which queues the words
// the block should return. A monitor pops results with random stalls and
// compares each one with the oldest queued word. Register settings change
// between phases once the block has drained. The phases cover the extremes of
// every register, a full popularity table, saturation of replica counts and
// random traffic drawn from a small id pool.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPLICA_SLOTS = pdrp_pkg::REPLICA_ENTRIES_DEF;
   localparam int POP_SLOTS     = pdrp_pkg::POPULARITY_ENTRIES_DEF;
   localparam int REPLICA_CAP   = pdrp_pkg::MAX_REPLICAS_DEF;
   localparam int STALL_LIMIT   = 20000;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   pdrp_pkg::req_word_type req_word;
   logic                   rsp_empty;
   logic                   rsp_pop;
   pdrp_pkg::rsp_word_type rsp_word;
   logic                   csr_we;
   logic [1:0]             csr_index;
   logic [10:0]            csr_wdata;

   popularity_driven_replica_placer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [10:0] cfg_nodes;
   logic [4:0]  cfg_default;
   logic [7:0]  cfg_period;
   logic [3:0]  cfg_boosts;
   logic [15:0] rep_ids [REPLICA_SLOTS];
   logic [4:0]  rep_cnts [REPLICA_SLOTS];
   int          rep_fill;
   logic [15:0] pop_ids [POP_SLOTS];
   logic [31:0] pop_cnts [POP_SLOTS];
   int          pop_fill;
   logic [7:0]  report_ctr;

   pdrp_pkg::req_word_type req_backlog[$];
   pdrp_pkg::rsp_word_type due_words[$];
   int           mismatches;
   int           stall_cycles;
   logic         no_idle;
   int           req_gap;
   int           rsp_gap;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic pdrp_pkg::rsp_word_type make_rsp(int node, int cnt, logic last,
                                                       logic full);
      pdrp_pkg::rsp_word_type r;
      r.node          = node[9:0];
      r.replica_count = cnt[4:0];
      r.last          = last;
      r.round_cleared = (report_ctr == 8'd0);
      r.table_full    = full;
      return r;
   endfunction

   function automatic void boost_popular();
      int best;
      for (int k = 0; k < int'(cfg_boosts); k++) begin
         if (pop_fill == 0) break;
         best = 0;
         for (int i = 0; i < pop_fill; i++)
            if (pop_cnts[best] < pop_cnts[i]) best = i;
         for (int i = 0; i < rep_fill; i++) begin
            if (rep_ids[i] == pop_ids[best]) begin
               if (int'(rep_cnts[i]) < REPLICA_CAP) rep_cnts[i] = rep_cnts[i] + 5'd1;
               break;
            end
         end
         pop_cnts[best] = 32'd0;
      end
      pop_fill   = 0;
      report_ctr = 8'd0;
   endfunction

   function automatic void place_or_report(pdrp_pkg::req_word_type w);
      logic        full;
      logic        found;
      logic [7:0]  period;
      logic [32:0] sum;
      int          cnt;
      int          modulus;
      int          n;
      full  = 1'b0;
      found = 1'b0;
      cnt   = 0;
      if (w.op == pdrp_pkg::OP_REPORT) begin
         if (w.entry_valid) begin
            for (int i = 0; i < pop_fill; i++) begin
               if (pop_ids[i] == w.data_id) begin
                  sum = {1'b0, pop_cnts[i]} + 33'(w.popularity_count);
                  pop_cnts[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  found = 1'b1;
                  break;
               end
            end
            if (!found) begin
               if (pop_fill < POP_SLOTS) begin
                  pop_ids[pop_fill]  = w.data_id;
                  pop_cnts[pop_fill] = {16'd0, w.popularity_count};
                  pop_fill++;
               end else begin
                  full = 1'b1;
               end
            end
         end
         if (w.end_of_report) begin
            period = (cfg_period == 8'd0) ? 8'd1 : cfg_period;
            report_ctr = report_ctr + 8'd1;
            if (report_ctr >= period) boost_popular();
         end
         due_words.push_back(make_rsp(0, 0, 1'b1, full));
      end else begin
         for (int i = 0; i < rep_fill; i++) begin
            if (rep_ids[i] == w.data_id) begin
               cnt   = int'(rep_cnts[i]);
               found = 1'b1;
               break;
            end
         end
         if (!found) begin
            if (rep_fill >= REPLICA_SLOTS) begin
               due_words.push_back(make_rsp(0, 0, 1'b1, 1'b1));
               return;
            end
            cnt = int'(cfg_default);
            if (cnt < 1) cnt = 1;
            if (cnt > REPLICA_CAP) cnt = REPLICA_CAP;
            rep_ids[rep_fill]  = w.data_id;
            rep_cnts[rep_fill] = cnt[4:0];
            rep_fill++;
         end
         modulus = int'(cfg_nodes);
         if (modulus == 0) modulus = 1;
         if (modulus > 1024) modulus = 1024;
         n = (cnt > 16) ? 16 : cnt;
         for (int i = 0; i < n; i++)
            due_words.push_back(make_rsp((int'(w.data_id) + i) % modulus, cnt,
                                         i + 1 == n, 1'b0));
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_word <= '0;
         req_gap  <= 0;
      end else begin
         if (req_push && !req_full) place_or_report(req_word);
         if (req_push && req_full) begin
            req_push <= 1'b1;
         end else if (req_gap > 0) begin
            req_gap  <= req_gap - 1;
            req_push <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            if (!no_idle && $urandom_range(0, 9) == 0) begin
               req_gap  <= $urandom_range(0, 14);
               req_push <= 1'b0;
            end else begin
               req_push <= 1'b1;
               req_word <= req_backlog.pop_front();
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop    <= 1'b0;
         rsp_gap    <= 0;
         mismatches <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_words.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected word: node %0d count %0d last %0b clr %0b full %0b",
                           rsp_word.node, rsp_word.replica_count, rsp_word.last,
                           rsp_word.round_cleared, rsp_word.table_full);
               mismatches <= mismatches + 1;
            end else begin
               if (rsp_word !== due_words[0]) begin
                  if (mismatches < 10)
                     $display({"mismatch: node %0d/%0d count %0d/%0d last %0b/%0b ",
                               "clr %0b/%0b full %0b/%0b (expected/actual)"},
                              due_words[0].node, rsp_word.node,
                              due_words[0].replica_count, rsp_word.replica_count,
                              due_words[0].last, rsp_word.last,
                              due_words[0].round_cleared, rsp_word.round_cleared,
                              due_words[0].table_full, rsp_word.table_full);
                  mismatches <= mismatches + 1;
               end
               void'(due_words.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_pop <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 14);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles where no word moves
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic pdrp_pkg::req_word_type make_req(logic op, logic [15:0] id,
                                                       logic [15:0] cnt, logic ev,
                                                       logic eor);
      pdrp_pkg::req_word_type w;
      w.op               = op;
      w.data_id          = id;
      w.popularity_count = cnt;
      w.entry_valid      = ev;
      w.end_of_report    = eor;
      return w;
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_push || due_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(pdrp_pkg::csr_index_type idx, logic [10:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         pdrp_pkg::CSR_NODE_COUNT:       cfg_nodes   = value;
         pdrp_pkg::CSR_DEFAULT_REPLICAS: cfg_default = value[4:0];
         pdrp_pkg::CSR_BOOST_PERIOD:     cfg_period  = value[7:0];
         pdrp_pkg::CSR_BOOST_COUNT:      cfg_boosts  = value[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_random(int count, logic [15:0] pool_base);
      logic [15:0] id;
      logic [15:0] cnt;
      for (int k = 0; k < count; k++) begin
         id  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                            : pool_base + 16'($urandom_range(0, 23));
         cnt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 999));
         if ($urandom_range(0, 1) == 0)
            req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, id, cnt,
                                           1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))));
         else
            req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, id, cnt,
                                           $urandom_range(0, 9) != 0,
                                           $urandom_range(0, 3) == 0));
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      no_idle    = 1'b0;
      cfg_nodes   = pdrp_pkg::NODE_COUNT_RST;
      cfg_default = pdrp_pkg::DEFAULT_REPLICAS_RST;
      cfg_period  = pdrp_pkg::BOOST_PERIOD_RST;
      cfg_boosts  = pdrp_pkg::BOOST_COUNT_RST;
      rep_fill   = 0;
      pop_fill   = 0;
      report_ctr = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words under reset settings
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b1, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h1234, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0000, 16'h0001, 1'b0, 1'b1));
      for (int k = 0; k < 9; k++)
         req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0000, 16'h0010,
                                        1'b1, 1'b1));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
      drain();

      // clamps and extremes: zero modulus, zero default, zero period, no picks
      write_reg(pdrp_pkg::CSR_NODE_COUNT, 11'd0);
      write_reg(pdrp_pkg::CSR_DEFAULT_REPLICAS, 11'd0);
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd0);
      write_reg(pdrp_pkg::CSR_BOOST_COUNT, 11'd0);
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h0042, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0042, 16'h0005, 1'b1, 1'b1));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b1));
      drain();

      // above-range modulus and default, max picks, replica count saturation
      write_reg(pdrp_pkg::CSR_NODE_COUNT, 11'h7FF);
      write_reg(pdrp_pkg::CSR_DEFAULT_REPLICAS, 11'h1F);
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd1);
      write_reg(pdrp_pkg::CSR_BOOST_COUNT, 11'hF);
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'hFC00, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'hFC00, 16'h0009, 1'b1, 1'b1));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'hFC00, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0042, 16'h0003, 1'b1, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h0000, 16'h0007, 1'b1, 1'b1));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h0042, 16'h0000, 1'b0, 1'b0));
      drain();

      // fill the popularity table past its end, then boost it
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd255);
      write_reg(pdrp_pkg::CSR_NODE_COUNT, 11'd1024);
      write_reg(pdrp_pkg::CSR_DEFAULT_REPLICAS, 11'd16);
      for (int k = 0; k < POP_SLOTS + 3; k++)
         req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h1000 + 16'(k), 16'(k),
                                        1'b1, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h1040, 16'h0000, 1'b0, 1'b0));
      req_backlog.push_back(make_req(pdrp_pkg::OP_PLACE, 16'h1003, 16'h0000, 1'b0, 1'b0));
      drain();
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd1);
      req_backlog.push_back(make_req(pdrp_pkg::OP_REPORT, 16'h1003, 16'h0001, 1'b1, 1'b1));
      drain();

      // random traffic under several settings
      write_reg(pdrp_pkg::CSR_NODE_COUNT, 11'd8);
      write_reg(pdrp_pkg::CSR_DEFAULT_REPLICAS, 11'd3);
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd3);
      write_reg(pdrp_pkg::CSR_BOOST_COUNT, 11'd2);
      queue_random(20, 16'h2000);
      drain();
      write_reg(pdrp_pkg::CSR_NODE_COUNT, 11'd1);
      write_reg(pdrp_pkg::CSR_DEFAULT_REPLICAS, 11'd5);
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd2);
      write_reg(pdrp_pkg::CSR_BOOST_COUNT, 11'd8);
      queue_random(20, 16'h2000);
      drain();

      // last stretch without idling
      no_idle = 1'b1;
      write_reg(pdrp_pkg::CSR_NODE_COUNT, 11'd13);
      write_reg(pdrp_pkg::CSR_BOOST_PERIOD, 11'd4);
      write_reg(pdrp_pkg::CSR_BOOST_COUNT, 11'd3);
      queue_random(20, 16'h8000);
      drain();
      repeat (50) @(posedge clock);

      if (mismatches == 0 && due_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
